// ===== rtl/sbr_pkg.sv =====
// Package: shared constants, types and helpers of the stack blur block.
package sbr_pkg;
    localparam int MaxWidth   = 64;
    localparam int MaxHeight  = 64;
    localparam int MaxRadius  = 15;
    localparam int Depth      = MaxWidth * MaxHeight;
    localparam int AddrW      = $clog2(Depth);
    localparam int CntW       = $clog2(Depth + 1);
    localparam int XW         = $clog2(MaxWidth + 1);
    localparam int YW         = $clog2(MaxHeight + 1);
    localparam int RW         = $clog2(MaxRadius + 1);
    localparam int CfgW       = 7;
    localparam int SumW       = 8 + 2 * RW + 1;

    localparam logic [1:0] CfgWidth  = 2'd0;
    localparam logic [1:0] CfgHeight = 2'd1;
    localparam logic [1:0] CfgRadius = 2'd2;

    localparam logic ActLoad = 1'b0;
    localparam logic ActRead = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       last_pixel;
        logic       status;
    } t_out_item;

    // Queued command from front to back.
    typedef struct packed {
        logic        is_load;
        logic        not_ready;
        logic        last;
        logic        run_pass;
        logic [31:0] pixel;
        logic [AddrW-1:0] addr;
        logic [XW-1:0] x;
        logic [YW-1:0] y;
    } t_cmd;

    function automatic logic [XW-1:0] sat_w(input logic [CfgW-1:0] v);
        if (v == '0) return XW'(1);
        if (32'(v) > MaxWidth) return XW'(MaxWidth);
        return XW'(v);
    endfunction

    function automatic logic [YW-1:0] sat_h(input logic [CfgW-1:0] v);
        if (v == '0) return YW'(1);
        if (32'(v) > MaxHeight) return YW'(MaxHeight);
        return YW'(v);
    endfunction

    function automatic logic [RW-1:0] sat_r(input logic [3:0] v);
        if (v == '0) return RW'(1);
        if (32'(v) > MaxRadius) return RW'(MaxRadius);
        return RW'(v);
    endfunction
endpackage

// ===== rtl/sbr_stream_if.sv =====
// Interface: valid/ready channel carrying one payload.
interface sbr_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sbr_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
module sbr_ram #(
    parameter int Width = 32,
    parameter int Depth = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== rtl/sbr_front.sv =====
// Front end: tracks load/read counters and turns beats into commands.
module sbr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [6:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sbr_pkg::t_in_item    i_in,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output sbr_pkg::t_cmd        o_cmd,
    output logic [sbr_pkg::XW-1:0] o_w,
    output logic [sbr_pkg::YW-1:0] o_h,
    output logic [sbr_pkg::RW-1:0] o_r
);
    import sbr_pkg::*;
    logic [CfgW-1:0] r_width, r_height;
    logic [3:0]      r_radius;
    logic [CntW-1:0] r_load, r_read;
    logic [XW-1:0]   r_lx, r_rx;
    logic [YW-1:0]   r_ly, r_ry;
    logic            r_ready;
    logic [XW-1:0]   w;
    logic [YW-1:0]   h;
    logic [CntW-1:0] total, lc;
    logic [XW-1:0]   lx;
    logic [YW-1:0]   ly;
    logic            fire;

    assign w = sat_w(r_width);
    assign h = sat_h(r_height);
    assign o_w = w;
    assign o_h = h;
    assign o_r = sat_r(r_radius);
    assign total = CntW'(w) * CntW'(h);
    assign o_in_ready = i_cmd_ready;
    assign o_cmd_valid = i_in_valid;
    assign fire = i_in_valid & i_cmd_ready;

    always_comb begin
        lc = r_load; lx = r_lx; ly = r_ly;
        if (r_ready || r_load >= total) begin
            lc = '0; lx = '0; ly = '0;
        end
        o_cmd = '0;
        o_cmd.is_load = (i_in.action == ActLoad);
        o_cmd.pixel = {i_in.alpha_in, i_in.blue_in, i_in.green_in, i_in.red_in};
        if (o_cmd.is_load) begin
            o_cmd.addr = AddrW'(lc);
            o_cmd.run_pass = (lc + 1'b1 == total);
        end else begin
            o_cmd.not_ready = ~r_ready;
            o_cmd.x = r_rx;
            o_cmd.y = r_ry;
            o_cmd.last = (r_read == total - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 7'd64; r_height <= 7'd64; r_radius <= 4'd1;
            r_load <= '0; r_read <= '0; r_ready <= 1'b0;
            r_lx <= '0; r_ly <= '0; r_rx <= '0; r_ry <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgWidth:  r_width  <= i_cfg_data;
                CfgHeight: r_height <= i_cfg_data;
                CfgRadius: r_radius <= i_cfg_data[3:0];
                default: ;
            endcase
            if (i_cfg_idx == CfgWidth || i_cfg_idx == CfgHeight || i_cfg_idx == CfgRadius) begin
                r_load <= '0; r_read <= '0; r_ready <= 1'b0;
                r_lx <= '0; r_ly <= '0; r_rx <= '0; r_ry <= '0;
            end
        end else if (fire) begin
            if (o_cmd.is_load) begin
                if (o_cmd.run_pass) begin
                    r_ready <= 1'b1; r_load <= '0; r_read <= '0;
                    r_lx <= '0; r_ly <= '0; r_rx <= '0; r_ry <= '0;
                end else begin
                    r_ready <= 1'b0;
                    r_load <= lc + 1'b1;
                    if (lx + 1'b1 == w) begin
                        r_lx <= '0; r_ly <= ly + 1'b1;
                    end else begin
                        r_lx <= lx + 1'b1; r_ly <= ly;
                    end
                end
            end else if (r_ready) begin
                if (o_cmd.last) begin
                    r_read <= '0; r_rx <= '0; r_ry <= '0;
                end else begin
                    r_read <= r_read + 1'b1;
                    if (r_rx + 1'b1 == w) begin
                        r_rx <= '0; r_ry <= r_ry + 1'b1;
                    end else begin
                        r_rx <= r_rx + 1'b1;
                    end
                end
            end
        end
    end
endmodule

// ===== rtl/sbr_queue.sv =====
// Two-entry command queue between front and back.
module sbr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sbr_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output sbr_pkg::t_cmd o_cmd
);
    import sbr_pkg::*;
    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;
    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];
    assign push = i_valid & o_ready;
    assign pop = o_valid & i_ready;
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== rtl/sbr_back.sv =====
// Back end: frame stores, horizontal pass sweep and per-read vertical blur.
module sbr_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  sbr_pkg::t_cmd          i_cmd,
    input  logic [sbr_pkg::XW-1:0] i_w,
    input  logic [sbr_pkg::YW-1:0] i_h,
    input  logic [sbr_pkg::RW-1:0] i_r,
    output logic                   o_valid,
    input  logic                   i_ready,
    output sbr_pkg::t_out_item     o_out
);
    import sbr_pkg::*;
    typedef enum logic [2:0] {
        S_IDLE, S_HPIX, S_VPIX, S_DIV, S_OUT
    } t_state;
    t_state r_state;
    logic        r_horiz;
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic signed [RW+1:0] r_k;
    logic        r_rdv;
    logic [RW:0] r_wt;
    logic [SumW-1:0] r_sum [4];
    logic [SumW-1:0] r_rem [4];
    logic [7:0]  r_q [4];
    logic [3:0]  r_dbit;
    logic [2*RW+1:0] r_div;
    logic        r_last;
    logic        r_done;
    t_out_item   r_out;
    logic        r_ov;

    logic             f_we;
    logic [AddrW-1:0] f_ra, rb_ra;
    logic [31:0]      f_rd, rb_rd, hw_data;
    logic             hw_we;
    logic [AddrW-1:0] hw_addr;

    sbr_ram #(.Width(32), .Depth(Depth)) u_frame (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(i_cmd.addr), .i_wdata(i_cmd.pixel),
        .i_raddr(f_ra), .o_rdata(f_rd));
    sbr_ram #(.Width(32), .Depth(Depth)) u_rowblur (
        .i_clk(i_clk), .i_we(hw_we), .i_waddr(hw_addr), .i_wdata(hw_data),
        .i_raddr(rb_ra), .o_rdata(rb_rd));

    logic accept;
    assign o_ready = (r_state == S_IDLE) & ~r_ov;
    assign accept = i_valid & o_ready;
    assign f_we = accept & i_cmd.is_load;

    // Clamped neighbour coordinate for the current tap.
    logic signed [8:0] qs;
    logic [6:0] qc;
    always_comb begin
        qs = r_horiz ? 9'($signed({2'b0, r_x})) + 9'(r_k)
                     : 9'($signed({2'b0, r_y})) + 9'(r_k);
        if (qs < 0) qc = '0;
        else if (r_horiz && qs > 9'(i_w) - 9'sd1) qc = 7'(i_w - 1'b1);
        else if (!r_horiz && qs > 9'(i_h) - 9'sd1) qc = 7'(i_h - 1'b1);
        else qc = 7'(qs);
        f_ra  = AddrW'(r_y) * AddrW'(i_w) + AddrW'(qc);
        rb_ra = AddrW'(qc) * AddrW'(i_w) + AddrW'(r_x);
    end

    logic signed [RW+1:0] absk;
    assign absk = r_k < 0 ? -r_k : r_k;

    always_comb begin
        hw_we = (r_state == S_DIV) && r_horiz && r_dbit == 4'd0 && r_done;
        hw_addr = AddrW'(r_y) * AddrW'(i_w) + AddrW'(r_x);
        hw_data = {r_q[3], r_q[2], r_q[1], r_q[0]};
    end

    logic [31:0] rd;
    assign rd = r_horiz ? f_rd : rb_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ov <= 1'b0; r_rdv <= 1'b0; r_done <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_rdv <= 1'b0;
                    r_k <= -$signed({2'b0, i_r});
                    for (int c = 0; c < 4; c++) r_sum[c] <= '0;
                    r_div <= (2*RW+2)'({1'b0, i_r} + 1'b1) * (2*RW+2)'({1'b0, i_r} + 1'b1);
                    if (accept) begin
                        if (i_cmd.is_load) begin
                            if (i_cmd.run_pass) begin
                                r_horiz <= 1'b1; r_x <= '0; r_y <= '0;
                                r_state <= S_HPIX;
                            end
                        end else if (i_cmd.not_ready) begin
                            r_out <= '{red_out: 8'd0, green_out: 8'd0, blue_out: 8'd0,
                                       alpha_out: 8'd0, last_pixel: 1'b0, status: 1'b1};
                            r_ov <= 1'b1;
                        end else begin
                            r_horiz <= 1'b0; r_x <= i_cmd.x; r_y <= i_cmd.y;
                            r_last <= i_cmd.last;
                            r_state <= S_VPIX;
                        end
                    end
                end
                S_HPIX, S_VPIX: begin
                    // Issue one tap a cycle; accumulate the tap read last cycle.
                    if (r_rdv) begin
                        for (int c = 0; c < 4; c++)
                            r_sum[c] <= r_sum[c] + SumW'(rd[8*c +: 8]) * SumW'(r_wt);
                    end
                    if (r_k <= $signed({2'b0, i_r})) begin
                        r_rdv <= 1'b1;
                        r_wt <= (RW+1)'($signed({2'b0, i_r}) + 1 - absk);
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_rdv <= 1'b0;
                        if (!r_rdv) begin
                            for (int c = 0; c < 4; c++) begin
                                r_rem[c] <= r_sum[c]; r_q[c] <= '0;
                            end
                            r_dbit <= 4'd7; r_done <= 1'b0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    // Restoring division, one quotient bit a cycle.
                    if (!r_done) begin
                        for (int c = 0; c < 4; c++) begin
                            if (r_rem[c] >= (SumW'(r_div) << r_dbit)) begin
                                r_rem[c] <= r_rem[c] - (SumW'(r_div) << r_dbit);
                                r_q[c][r_dbit[2:0]] <= 1'b1;
                            end
                        end
                        if (r_dbit == 4'd0) r_done <= 1'b1;
                        else r_dbit <= r_dbit - 1'b1;
                    end else begin
                        r_done <= 1'b0;
                        r_k <= -$signed({2'b0, i_r});
                        for (int c = 0; c < 4; c++) r_sum[c] <= '0;
                        if (r_horiz) begin
                            if (r_x + 1'b1 == i_w) begin
                                r_x <= '0;
                                if (r_y + 1'b1 == i_h) r_state <= S_IDLE;
                                else begin
                                    r_y <= r_y + 1'b1; r_state <= S_HPIX;
                                end
                            end else begin
                                r_x <= r_x + 1'b1; r_state <= S_HPIX;
                            end
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ov) begin
                        r_out.red_out <= r_q[0]; r_out.green_out <= r_q[1];
                        r_out.blue_out <= r_q[2]; r_out.alpha_out <= r_q[3];
                        r_out.last_pixel <= r_last; r_out.status <= 1'b0;
                        r_ov <= 1'b1; r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
    assign o_valid = r_ov;
    assign o_out = r_out;
endmodule

// ===== rtl/stack_blur_rgba_frame.sv =====
// Top level: stack blur of an RGBA frame with load and read beats.
// Timing: the last load beat starts a horizontal pass over the frame, paced per pixel
// by the one-tap-per-cycle frame store port and the bit-serial divider. The back end
// takes a read beat, blurs it vertically and takes no new beat until its result has left.
// Reads before the frame is loaded answer with status set.
// Reset (synchronous, active low) clears counters, ready flag and registers to defaults.
module stack_blur_rgba_frame (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [6:0]           i_cfg_data,
    sbr_stream_if.sink           s_in,
    sbr_stream_if.source         m_out
);
    import sbr_pkg::*;
    logic c_valid, c_ready, q_valid, q_ready;
    t_cmd c_cmd, q_cmd;
    logic [XW-1:0] w;
    logic [YW-1:0] h;
    logic [RW-1:0] r;

    // Front end classifies beats and keeps the frame counters.
    sbr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in_valid(s_in.valid), .o_in_ready(s_in.ready),
        .i_in(s_in.data), .o_cmd_valid(c_valid), .i_cmd_ready(c_ready), .o_cmd(c_cmd),
        .o_w(w), .o_h(h), .o_r(r));

    sbr_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(c_valid), .o_ready(c_ready),
        .i_cmd(c_cmd), .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd));

    // Back end owns both stores and the blur datapath.
    sbr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_ready(q_ready),
        .i_cmd(q_cmd), .i_w(w), .i_h(h), .i_r(r), .o_valid(m_out.valid),
        .i_ready(m_out.ready), .o_out(m_out.data));

    // A result beat never flags both not-ready and last pixel.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> !(m_out.data.status && m_out.data.last_pixel))
        else $error("status and last_pixel both set");
    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> (m_out.valid && $stable(m_out.data)))
        else $error("result changed while stalled");
endmodule
